// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Needs nothing else; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// hold: antecedent implies consequent at the same edge
`define CSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// hold: antecedent implies consequent a fixed number of edges later
`define CSC_ASSERT_DELAY(label, clk, rst_n, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/csc_pkg.sv =====
// Shared types, codes and coefficient table of the colour space converter.
// Needs nothing; used by the top level and its checker.
package csc_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COEF_BITS   = 17;
  localparam int COEF_FRAC   = 14;
  localparam int PROD_BITS   = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS    = PROD_BITS + 2;
  localparam int RND_BITS    = ACC_BITS - COEF_FRAC;
  localparam int LATENCY     = 4;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CSPACE  = 2'd0,
    CFG_INVERSE = 2'd1,
    CFG_MONO    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CS_YUV   = 2'd0,
    CS_YCBCR = 2'd1,
    CS_OPP   = 2'd2,
    CS_RGB   = 2'd3
  } cspace_t;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef coef_t [2:0] coef_row_t;
  typedef coef_row_t [2:0] coef_mat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ch0_in;
    logic signed [SAMPLE_BITS-1:0] ch1_in;
    logic signed [SAMPLE_BITS-1:0] ch2_in;
    logic                          last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] ch0_out;
    logic signed [SAMPLE_BITS-1:0] ch1_out;
    logic signed [SAMPLE_BITS-1:0] ch2_out;
    logic                          last_out;
  } out_req_t;

  function automatic coef_row_t mk_row(int a, int b, int c);
    coef_row_t row;
    row[0] = COEF_BITS'(a);
    row[1] = COEF_BITS'(b);
    row[2] = COEF_BITS'(c);
    return row;
  endfunction

  // Q3.14 matrix, [output row][input column]
  function automatic coef_mat_t coef_sel(cspace_t cs, logic inv);
    coef_mat_t m;
    m[0] = mk_row(0, 0, 0);
    m[1] = mk_row(0, 0, 0);
    m[2] = mk_row(0, 0, 0);
    case (cs)
      CS_YUV: begin
        if (!inv) begin
          m[0] = mk_row(4899, 9617, 1868);
          m[1] = mk_row(-2411, -4733, 7143);
          m[2] = mk_row(10076, -8437, -1639);
        end else begin
          m[0] = mk_row(16384, 0, 18675);
          m[1] = mk_row(16384, -6466, -9513);
          m[2] = mk_row(16384, 33294, 0);
        end
      end
      CS_YCBCR: begin
        if (!inv) begin
          m[0] = mk_row(4899, 9617, 1868);
          m[1] = mk_row(-2769, -5423, 8192);
          m[2] = mk_row(8192, -6865, -1327);
        end else begin
          m[0] = mk_row(16384, 0, 22970);
          m[1] = mk_row(16384, -5636, -11698);
          m[2] = mk_row(16384, 29032, 0);
        end
      end
      CS_OPP: begin
        if (!inv) begin
          m[0] = mk_row(5456, 5456, 5456);
          m[1] = mk_row(-8192, 0, 8192);
          m[2] = mk_row(4096, -8192, 4096);
        end else begin
          m[0] = mk_row(16384, -16384, 10912);
          m[1] = mk_row(16384, 0, -21840);
          m[2] = mk_row(16384, 16384, 10912);
        end
      end
      default: begin
        m[0] = mk_row(0, 0, 0);
      end
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/color_space_converter.sv =====
// Colour space converter top level: pipelined 3x3 matrix per pixel, or pass-through in mono or RGB mode.
// Depends on csc_pkg for request types, codes and the coefficient table.
//
// Use:
//   Input requests: drive in_data and raise start; a request is taken at
//   every rising edge with start high and busy low. busy is high only while
//   rst_n is low, so one pixel per clock is taken in normal running.
//   Results: out_data is valid for exactly one cycle while out_valid is
//   high; the receiver must take it then, it cannot hold results off.
//   Pipeline: a pixel taken at a rising edge passes four register stages
//   (operand/coefficient select, products, rounded row sums, saturation)
//   before it is shown on out_data. Throughput: one pixel per clock, set by
//   the nine multipliers of the product stage, one per matrix entry.
//   Configuration: cfg_we, cfg_index, cfg_wdata write the space select (0),
//   inverse (1) or mono (2) at a rising edge; index 3 is ignored. Write
//   only while no pixel is in flight.
//   Reset: synchronous, active low; clears all stage valid bits and sets
//   the space select to opponent, inverse and mono to 0. Pixels in flight
//   are dropped.
module color_space_converter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  csc_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  output csc_pkg::out_req_t                   out_data,
  input  logic                                cfg_we,
  input  logic [csc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [csc_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
  import csc_pkg::*;

  localparam logic signed [ACC_BITS-1:0] RND_HALF = ACC_BITS'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  cspace_t cspace_r;
  logic    inverse_r;
  logic    mono_r;
  logic    in_acc;

  logic                          s1_vld_r;
  logic signed [SAMPLE_BITS-1:0] s1_smp_r [3];
  coef_mat_t                     s1_coef_r;
  logic                          s1_pass_r;
  logic                          s1_last_r;

  logic                          s2_vld_r;
  logic signed [PROD_BITS-1:0]   s2_prod_r [3][3];
  logic signed [SAMPLE_BITS-1:0] s2_smp_r [3];
  logic                          s2_pass_r;
  logic                          s2_last_r;

  logic                          s3_vld_r;
  logic signed [RND_BITS-1:0]    s3_rnd_r [3];
  logic signed [SAMPLE_BITS-1:0] s3_smp_r [3];
  logic                          s3_pass_r;
  logic                          s3_last_r;

  logic signed [ACC_BITS-1:0]    sum_nxt [3];
  logic signed [SAMPLE_BITS-1:0] sat_nxt [3];
  logic signed [SAMPLE_BITS-1:0] res_nxt [3];

  logic     out_valid_r;
  out_req_t out_data_r;

  assign busy   = !rst_n;
  assign in_acc = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cspace_r  <= CS_OPP;
      inverse_r <= 1'b0;
      mono_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CSPACE:  cspace_r  <= cspace_t'(cfg_wdata);
        CFG_INVERSE: inverse_r <= cfg_wdata[0];
        CFG_MONO:    mono_r    <= cfg_wdata[0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= in_acc;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_smp_r[0] <= in_data.ch0_in;
    s1_smp_r[1] <= in_data.ch1_in;
    s1_smp_r[2] <= in_data.ch2_in;
    s1_coef_r   <= coef_sel(cspace_r, inverse_r);
    s1_pass_r   <= mono_r || (cspace_r == CS_RGB);
    s1_last_r   <= in_data.last_in;
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        s2_prod_r[r][c] <= $signed(s1_coef_r[r][c]) * s1_smp_r[c];
      end
    end
    s2_smp_r  <= s1_smp_r;
    s2_pass_r <= s1_pass_r;
    s2_last_r <= s1_last_r;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum_nxt[r] = ACC_BITS'(s2_prod_r[r][0]) + ACC_BITS'(s2_prod_r[r][1])
                 + ACC_BITS'(s2_prod_r[r][2]) + RND_HALF;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      s3_rnd_r[r] <= sum_nxt[r][ACC_BITS-1:COEF_FRAC];
    end
    s3_smp_r  <= s2_smp_r;
    s3_pass_r <= s2_pass_r;
    s3_last_r <= s2_last_r;
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      if (&s3_rnd_r[r][RND_BITS-1:SAMPLE_BITS-1] || ~|s3_rnd_r[r][RND_BITS-1:SAMPLE_BITS-1]) begin
        sat_nxt[r] = s3_rnd_r[r][SAMPLE_BITS-1:0];
      end else if (s3_rnd_r[r][RND_BITS-1]) begin
        sat_nxt[r] = SAT_MIN;
      end else begin
        sat_nxt[r] = SAT_MAX;
      end
      res_nxt[r] = s3_pass_r ? s3_smp_r[r] : sat_nxt[r];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.ch0_out  <= res_nxt[0];
    out_data_r.ch1_out  <= res_nxt[1];
    out_data_r.ch2_out  <= res_nxt[2];
    out_data_r.last_out <= s3_last_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/csc_checker.sv =====
// Port-level checker for the colour space converter, bound to the top level.
// Depends on csc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module csc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input csc_pkg::in_req_t  in_data,
  input logic              out_valid,
  input csc_pkg::out_req_t out_data
);
  import csc_pkg::*;

  logic acc;
  assign acc = start && !busy;

  `CSC_ASSERT_DELAY(a_req_to_res, clk, rst_n, acc, LATENCY, out_valid, "request lost in pipeline")
  `CSC_ASSERT_IMPLY(a_res_has_req, clk, rst_n, out_valid, $past(acc, LATENCY), "result without request")
  `CSC_ASSERT_IMPLY(a_last_kept, clk, rst_n, out_valid, out_data.last_out == $past(in_data.last_in, LATENCY), "last flag mismatch")

endmodule

bind color_space_converter csc_checker u_csc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
